/* hdl/ute_pkg.sv */
// shared types, constants and tables of the timestamp to epoch converter
`timescale 1ns / 1ps

package ute_pkg;

    // longest accepted timestamp text, bytes
    localparam int MAX_LENGTH = 32;
    localparam int IDX_W      = $clog2(MAX_LENGTH + 1);

    localparam int YEAR_W = 14;
    localparam int ACC_W  = 7;
    localparam int DAYS_W = 22;
    localparam int HMS_W  = 17;
    localparam int SECS_W = 38;
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    // ascii codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DASH  = 8'h2d;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_Z     = 8'h5a;

    // position kinds in the fixed part of the text
    localparam logic [3:0] KIND_YEAR   = 4'd0;
    localparam logic [3:0] KIND_MONTH  = 4'd1;
    localparam logic [3:0] KIND_DAY    = 4'd2;
    localparam logic [3:0] KIND_HOUR   = 4'd3;
    localparam logic [3:0] KIND_MINUTE = 4'd4;
    localparam logic [3:0] KIND_SECOND = 4'd5;
    localparam logic [3:0] KIND_DASH   = 4'd6;
    localparam logic [3:0] KIND_TEE    = 4'd7;
    localparam logic [3:0] KIND_COLON  = 4'd8;
    localparam logic [3:0] KIND_END    = 4'd9;

    // one parsed timestamp handed from the parser to the calculator
    typedef struct packed {
        logic              err;
        logic [YEAR_W-1:0] year;
        logic [ACC_W-1:0]  month;
        logic [ACC_W-1:0]  day;
        logic [ACC_W-1:0]  hour;
        logic [ACC_W-1:0]  minute;
        logic [ACC_W-1:0]  second;
    } t_rec;

    function automatic logic [3:0] pos_kind(input logic [4:0] idx);
        logic [3:0] k;
        unique case (idx)
            5'd0, 5'd1, 5'd2, 5'd3:   k = KIND_YEAR;
            5'd4, 5'd7:               k = KIND_DASH;
            5'd5, 5'd6:               k = KIND_MONTH;
            5'd8, 5'd9:               k = KIND_DAY;
            5'd10:                    k = KIND_TEE;
            5'd11, 5'd12:             k = KIND_HOUR;
            5'd13, 5'd16:             k = KIND_COLON;
            5'd14, 5'd15:             k = KIND_MINUTE;
            5'd17, 5'd18:             k = KIND_SECOND;
            default:                  k = KIND_END;
        endcase
        return k;
    endfunction

    // days before the first of the month, non-leap year
    function automatic logic [8:0] cum_days(input logic [3:0] month);
        logic [8:0] c;
        unique case (month)
            4'd1:    c = 9'd0;
            4'd2:    c = 9'd31;
            4'd3:    c = 9'd59;
            4'd4:    c = 9'd90;
            4'd5:    c = 9'd120;
            4'd6:    c = 9'd151;
            4'd7:    c = 9'd181;
            4'd8:    c = 9'd212;
            4'd9:    c = 9'd243;
            4'd10:   c = 9'd273;
            4'd11:   c = 9'd304;
            4'd12:   c = 9'd334;
            default: c = 9'd0;
        endcase
        return c;
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
        logic [4:0] c;
        unique case (month)
            4'd2:                      c = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   c = 5'd30;
            default:                   c = 5'd31;
        endcase
        return c;
    endfunction

endpackage

/* hdl/ute_front.sv */
// byte parser: checks the text format and accumulates the date and time fields
`timescale 1ns / 1ps

module ute_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [7:0]          i_char_code,
    input  logic                i_last_char,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_q_full,
    output logic                o_push,
    output ute_pkg::t_rec       o_rec
);

    localparam logic [ute_pkg::IDX_W-1:0] IDX_MAX = ute_pkg::IDX_W'(ute_pkg::MAX_LENGTH);
    localparam logic [ute_pkg::IDX_W-1:0] IDX_19  = ute_pkg::IDX_W'(19);
    localparam logic [ute_pkg::IDX_W-1:0] IDX_20  = ute_pkg::IDX_W'(20);
    localparam logic [ute_pkg::IDX_W-1:0] IDX_21  = ute_pkg::IDX_W'(21);

    logic [ute_pkg::IDX_W-1:0]  r_idx, n_idx;
    logic [ute_pkg::YEAR_W-1:0] r_year, n_year;
    logic [ute_pkg::ACC_W-1:0]  r_month, n_month;
    logic [ute_pkg::ACC_W-1:0]  r_day, n_day;
    logic [ute_pkg::ACC_W-1:0]  r_hour, n_hour;
    logic [ute_pkg::ACC_W-1:0]  r_minute, n_minute;
    logic [ute_pkg::ACC_W-1:0]  r_second, n_second;
    logic                       r_frac, n_frac;
    logic                       r_err;
    logic                       err;
    logic                       acc;
    logic                       digit;
    logic [3:0]                 dig;
    logic [3:0]                 kind;

    assign o_ready = !i_q_full;
    assign acc     = i_valid && o_ready;
    assign digit   = (i_char_code >= ute_pkg::CH_ZERO) && (i_char_code <= ute_pkg::CH_NINE);
    assign dig     = digit ? 4'(i_char_code - ute_pkg::CH_ZERO) : 4'd0;
    assign kind    = ute_pkg::pos_kind(r_idx[4:0]);

    always_comb begin
        err      = r_err;
        n_year   = r_year;
        n_month  = r_month;
        n_day    = r_day;
        n_hour   = r_hour;
        n_minute = r_minute;
        n_second = r_second;
        n_frac   = r_frac;
        if (r_idx >= IDX_MAX) begin
            err = 1'b1;
        end else if (r_idx < IDX_20) begin
            unique case (kind)
                ute_pkg::KIND_YEAR: begin
                    if (!digit) err = 1'b1;
                    else n_year = ute_pkg::YEAR_W'(r_year * 14'd10 + 14'(dig));
                end
                ute_pkg::KIND_MONTH: begin
                    if (!digit) err = 1'b1;
                    else n_month = ute_pkg::ACC_W'(r_month * 7'd10 + 7'(dig));
                end
                ute_pkg::KIND_DAY: begin
                    if (!digit) err = 1'b1;
                    else n_day = ute_pkg::ACC_W'(r_day * 7'd10 + 7'(dig));
                end
                ute_pkg::KIND_HOUR: begin
                    if (!digit) err = 1'b1;
                    else n_hour = ute_pkg::ACC_W'(r_hour * 7'd10 + 7'(dig));
                end
                ute_pkg::KIND_MINUTE: begin
                    if (!digit) err = 1'b1;
                    else n_minute = ute_pkg::ACC_W'(r_minute * 7'd10 + 7'(dig));
                end
                ute_pkg::KIND_SECOND: begin
                    if (!digit) err = 1'b1;
                    else n_second = ute_pkg::ACC_W'(r_second * 7'd10 + 7'(dig));
                end
                ute_pkg::KIND_DASH: begin
                    if (i_char_code != ute_pkg::CH_DASH) err = 1'b1;
                end
                ute_pkg::KIND_TEE: begin
                    if (i_char_code != ute_pkg::CH_T) err = 1'b1;
                end
                ute_pkg::KIND_COLON: begin
                    if (i_char_code != ute_pkg::CH_COLON) err = 1'b1;
                end
                default: begin
                    // seconds end: 'Z' closes, '.' opens the fraction
                    if (i_char_code == ute_pkg::CH_DOT) begin
                        n_frac = 1'b1;
                        if (i_last_char) err = 1'b1;
                    end else if (i_char_code != ute_pkg::CH_Z) begin
                        err = 1'b1;
                    end
                end
            endcase
        end else if (!r_frac) begin
            err = 1'b1;
        end else if (i_last_char) begin
            if (i_char_code != ute_pkg::CH_Z || r_idx < IDX_21) err = 1'b1;
        end else if (!digit) begin
            err = 1'b1;
        end
        if (i_last_char && r_idx < IDX_19) err = 1'b1;
        n_idx = (r_idx < IDX_MAX) ? ute_pkg::IDX_W'(r_idx + 1'b1) : IDX_MAX;
    end

    assign o_push       = acc && i_last_char;
    assign o_rec.err    = err;
    assign o_rec.year   = n_year;
    assign o_rec.month  = n_month;
    assign o_rec.day    = n_day;
    assign o_rec.hour   = n_hour;
    assign o_rec.minute = n_minute;
    assign o_rec.second = n_second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (acc && i_last_char)) begin
            r_idx    <= '0;
            r_year   <= '0;
            r_month  <= '0;
            r_day    <= '0;
            r_hour   <= '0;
            r_minute <= '0;
            r_second <= '0;
            r_frac   <= 1'b0;
            r_err    <= 1'b0;
        end else if (acc) begin
            r_idx    <= n_idx;
            r_year   <= n_year;
            r_month  <= n_month;
            r_day    <= n_day;
            r_hour   <= n_hour;
            r_minute <= n_minute;
            r_second <= n_second;
            r_frac   <= n_frac;
            r_err    <= err;
        end
    end

endmodule

/* hdl/ute_queue.sv */
// short register queue of parsed timestamps between parser and calculator
`timescale 1ns / 1ps

module ute_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ute_pkg::t_rec i_rec,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output ute_pkg::t_rec o_rec
);

    ute_pkg::t_rec                r_mem [ute_pkg::Q_DEPTH];
    logic [ute_pkg::Q_PTR_W-1:0]  r_wr, r_rd;
    logic [ute_pkg::Q_PTR_W:0]    r_cnt;
    logic                         push, pop;

    assign o_full  = (r_cnt == (ute_pkg::Q_PTR_W + 1)'(ute_pkg::Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign push    = i_push && !o_full;
    assign pop     = i_pop && !o_empty;
    assign o_rec   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr] <= i_rec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= r_wr + 1'b1;
            if (pop)  r_rd <= r_rd + 1'b1;
            if (push && !pop)      r_cnt <= r_cnt + 1'b1;
            else if (pop && !push) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

/* hdl/ute_back.sv */
// calculator: validates the date and converts it to unix seconds in three stages
`timescale 1ns / 1ps

module ute_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_empty,
    input  ute_pkg::t_rec                i_rec,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_valid_res,
    output logic [ute_pkg::SECS_W-1:0]   o_epoch_secs
);

    localparam logic [13:0] YEAR_EPOCH = 14'd1970;
    localparam logic [13:0] RECIP_100  = 14'd5243;

    logic en;

    // stage 1
    logic                         r1_vld;
    logic                         r1_ok;
    logic [ute_pkg::YEAR_W-1:0]   r1_year;
    logic [3:0]                   r1_month;
    logic [ute_pkg::ACC_W-1:0]    r1_day;
    logic [6:0]                   r1_q1, r1_qy;
    logic [8:0]                   r1_doy;
    logic [ute_pkg::HMS_W-1:0]    r1_hms;
    logic                         ok1;
    logic [ute_pkg::YEAR_W-1:0]   y1;
    logic [27:0]                  prod1, prody;
    logic [8:0]                   doy0;
    logic [ute_pkg::HMS_W-1:0]    hms;

    // stage 2
    logic                         r2_vld;
    logic                         r2_ok;
    logic [ute_pkg::DAYS_W-1:0]   r2_days;
    logic [ute_pkg::HMS_W-1:0]    r2_hms;
    logic [13:0]                  rem100;
    logic                         leap;
    logic [4:0]                   dim;
    logic [22:0]                  days;
    logic                         ok2;

    // output register
    logic                         r_out_vld;
    logic                         r_out_ok;
    logic [ute_pkg::SECS_W-1:0]   r_out_secs;

    assign en    = !r_out_vld || i_ready;
    assign o_pop = en && !i_empty;

    always_comb begin
        ok1 = !i_rec.err && (i_rec.hour <= 7'd23) && (i_rec.minute <= 7'd59) &&
              (i_rec.second <= 7'd59) && (i_rec.month >= 7'd1) && (i_rec.month <= 7'd12) &&
              (i_rec.day >= 7'd1) && (i_rec.year >= YEAR_EPOCH);
        y1    = i_rec.year - 1'b1;
        // divide by 100 through a reciprocal, exact below 10000
        prod1 = 28'(y1) * 28'(RECIP_100);
        prody = 28'(i_rec.year) * 28'(RECIP_100);
        doy0  = 9'(ute_pkg::cum_days(i_rec.month[3:0]) + 9'(i_rec.day) - 9'd1);
        hms   = ute_pkg::HMS_W'(17'(i_rec.hour[4:0]) * 17'd3600 +
                17'(i_rec.minute[5:0]) * 17'd60 + 17'(i_rec.second[5:0]));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_ok    <= ok1;
            r1_year  <= i_rec.year;
            r1_month <= i_rec.month[3:0];
            r1_day   <= i_rec.day;
            r1_q1    <= prod1[25:19];
            r1_qy    <= prody[25:19];
            r1_doy   <= doy0;
            r1_hms   <= hms;
        end
    end

    always_comb begin
        rem100 = r1_year - 14'(r1_qy) * 14'd100;
        leap   = (r1_year[1:0] == 2'b00 && rem100 != 14'd0) ||
                 (rem100 == 14'd0 && r1_qy[1:0] == 2'b00);
        dim    = ute_pkg::month_days(r1_month, leap);
        // days since 1970-01-01, with the leap days before this year counted from 1970
        days   = 23'(23'(r1_year - YEAR_EPOCH) * 23'd365 +
                 23'(ute_pkg::YEAR_W'(r1_year - 1'b1) >> 2) - 23'(r1_q1) +
                 23'(r1_q1[6:2]) - 23'd477 + 23'(r1_doy) +
                 23'(leap && r1_month > 4'd2));
        ok2    = r1_ok && (r1_day <= 7'(dim)) &&
                 !(days[ute_pkg::DAYS_W-1:0] == '0 && r1_hms == '0);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_ok   <= ok2;
            r2_days <= days[ute_pkg::DAYS_W-1:0];
            r2_hms  <= r1_hms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_ok   <= r2_ok;
            r_out_secs <= r2_ok ? ute_pkg::SECS_W'(38'(r2_days) * 38'd86400 + 38'(r2_hms))
                                : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r1_vld    <= !i_empty;
            r2_vld    <= r1_vld;
            r_out_vld <= r2_vld;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_valid_res  = r_out_ok;
    assign o_epoch_secs = r_out_secs;

endmodule

/* hdl/utc_timestamp_to_epoch.sv */
// top level of the utc timestamp to unix seconds converter
`timescale 1ns / 1ps

// Converts a UTC timestamp, fed one ASCII byte per transaction, into Unix
// seconds. Accepted forms are YYYY-MM-DDTHH:MM:SSZ and YYYY-MM-DDTHH:MM:SS.fffZ
// with one or more fraction digits, up to MAX_LENGTH bytes in total; the byte
// flagged by i_last_char ends a timestamp and produces exactly one output
// transaction, other bytes produce none. The output carries o_valid_res = 1
// and the seconds when the text is well formed, the date exists in the
// proleptic Gregorian calendar, the time is in range and it lies after
// 1970-01-01T00:00:00Z; otherwise o_valid_res = 0 and o_epoch_secs = 0.
// Fraction digits are checked and dropped. Bytes stream in at one per clock:
// the parser takes a byte every cycle while its four entry queue has room,
// and the calculator behind it runs a three stage pipeline (divide by
// reciprocal, day count, seconds multiply) that also accepts one timestamp
// per cycle when the output is not stalled; a finished timestamp passes
// through the queue, stage 1, stage 2 and the output register. Backpressure
// on i_ready holds the calculator; the queue absorbs up to four finished
// timestamps before o_ready drops.

module utc_timestamp_to_epoch (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // byte input channel
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [7:0]                   i_char_code,
    input  logic                         i_last_char,
    // result channel
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_valid_res,
    output logic [ute_pkg::SECS_W-1:0]   o_epoch_secs
);

    ute_pkg::t_rec push_rec;
    ute_pkg::t_rec pop_rec;
    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_empty;

    // front: format checks and field accumulation per byte
    ute_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_char_code (i_char_code),
        .i_last_char (i_last_char),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_rec       (push_rec)
    );

    // decoupling queue of parsed timestamps
    ute_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_rec   (pop_rec)
    );

    // back: calendar checks and seconds computation, output register
    ute_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (q_empty),
        .i_rec        (pop_rec),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_valid_res  (o_valid_res),
        .o_epoch_secs (o_epoch_secs)
    );

endmodule
